@@ hw/rtl/gil4_pkg.sv @@
// ----------------------------------------------------------------------------
// gil4_pkg
// Types and constants shared by the format-4 glyph index lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package gil4_pkg;

    localparam int REQ_DATA_W  = 112;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    // Signed width of the glyph array index before the range check.
    localparam int IDX_W       = 19;
    localparam int SCAN_W      = 13;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GLYPH_WORDS   = 2'd1;

    typedef enum logic [1:0] {
        REQ_SEG    = 2'd0,
        REQ_GLYPH  = 2'd1,
        REQ_LOOKUP = 2'd2
    } t_req_type;

    typedef enum logic [1:0] {
        ST_MAPPED = 2'd0,
        ST_UNCOV  = 2'd1,
        ST_OOR    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RES_UNCOV = 2'd0,
        RES_DELTA = 2'd1,
        RES_OOR   = 2'd2,
        RES_GLYPH = 2'd3
    } t_res_sel;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_SCAN  = 3'd1,
        S_CALC  = 3'd2,
        S_RANGE = 3'd3,
        S_GREAD = 3'd4,
        S_OUT   = 3'd5
    } t_state;

    // Input item payload, lowest field in the lowest bits.
    typedef struct packed {
        logic [3:0]  spare;
        logic [15:0] code_point;
        logic [15:0] glyph_word;
        logic [15:0] range_offset;
        logic [15:0] id_delta;
        logic [15:0] start_code;
        logic [15:0] stop_code;
        logic [11:0] table_index;
    } t_req;

    typedef struct packed {
        logic [15:0] range_offset;
        logic [15:0] id_delta;
        logic [15:0] start_code;
        logic [15:0] stop_code;
    } t_seg;

    typedef struct packed {
        logic     seg_wr;
        logic     glyph_wr;
        logic     code_load;
        logic     seg_clr;
        logic     seg_inc;
        logic     idx_load;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic end_ge;
        logic start_gt;
        logic ro_zero;
        logic scan_last;
        logic scan_zero;
        logic idx_oor;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

@@ hw/rtl/gil4_ctrl.sv @@
// ----------------------------------------------------------------------------
// gil4_ctrl
// Sequencer for loads and lookups: scans the segment store, then steps the
// datapath through the index arithmetic, the range check and the array read.
// ----------------------------------------------------------------------------
`default_nettype none

module gil4_ctrl
    import gil4_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_req_type,
    output logic            o_in_ready,
    input  wire t_sts       i_sts,
    output t_cmd            o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == REQ_LOOKUP)) begin
                    n_state = i_sts.scan_zero ? S_OUT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.end_ge) begin
                    n_state = S_CALC;
                end else if (i_sts.scan_last) begin
                    n_state = S_OUT;
                end
            end
            S_CALC: begin
                n_state = (i_sts.start_gt || i_sts.ro_zero) ? S_OUT : S_RANGE;
            end
            S_RANGE: begin
                n_state = i_sts.idx_oor ? S_OUT : S_GREAD;
            end
            S_GREAD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) begin
                    case (i_req_type)
                        REQ_SEG: begin
                            o_cmd.seg_wr = 1'b1;
                        end
                        REQ_GLYPH: begin
                            o_cmd.glyph_wr = 1'b1;
                        end
                        REQ_LOOKUP: begin
                            o_cmd.code_load = 1'b1;
                            o_cmd.seg_clr   = 1'b1;
                            o_cmd.res_load  = i_sts.scan_zero;
                            o_cmd.res_sel   = RES_UNCOV;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!i_sts.end_ge) begin
                    if (i_sts.scan_last) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = RES_UNCOV;
                    end else begin
                        o_cmd.seg_inc = 1'b1;
                    end
                end
            end
            S_CALC: begin
                o_cmd.idx_load = 1'b1;
                if (i_sts.start_gt) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_UNCOV;
                end else if (i_sts.ro_zero) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_DELTA;
                end
            end
            S_RANGE: begin
                if (i_sts.idx_oor) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_OOR;
                end
            end
            S_GREAD: begin
                o_cmd.res_load = 1'b1;
                o_cmd.res_sel  = RES_GLYPH;
            end
            S_OUT: begin
                o_cmd.out_load = i_sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

@@ hw/rtl/gil4_dp.sv @@
// ----------------------------------------------------------------------------
// gil4_dp
// Datapath: configuration registers, segment store, glyph array, index
// arithmetic, result register and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gil4_dp
    import gil4_pkg::*;
#(
    parameter int MAX_SEGMENTS      = 128,
    parameter int GLYPH_ARRAY_DEPTH = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire t_req                   i_req,
    input  wire t_cmd                   i_cmd,
    output t_sts                        o_sts,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [15:0]                 o_glyph_id,
    output logic [1:0]                  o_lookup_status
);

    localparam int SAW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int GAW = (GLYPH_ARRAY_DEPTH > 1) ? $clog2(GLYPH_ARRAY_DEPTH) : 1;

    logic [7:0]            r_seg_count;
    logic [CFG_DATA_W-1:0] r_glyph_words;

    t_seg                  r_seg_mem [MAX_SEGMENTS];
    t_seg                  r_seg_rd;
    logic [15:0]           r_glyph_mem [GLYPH_ARRAY_DEPTH];
    logic [15:0]           r_glyph_rd;

    logic [SAW-1:0]        r_idx;
    logic [SAW-1:0]        n_idx;
    logic [15:0]           r_code;
    logic [IDX_W-1:0]      r_gidx;
    logic [IDX_W-1:0]      glim;
    logic [SCAN_W-1:0]     scan_cnt;
    logic                  seg_idx_ok;
    logic                  glyph_idx_ok;

    logic [15:0]           r_res_gid;
    t_status               r_res_status;
    logic                  r_out_valid;
    logic [15:0]           r_out_gid;
    logic [1:0]            r_out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_count   <= 8'd1;
            r_glyph_words <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SEGMENT_COUNT: r_seg_count   <= i_cfg_wdata[7:0];
                CFG_GLYPH_WORDS:   r_glyph_words <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign seg_idx_ok   = {20'd0, i_req.table_index} < 32'(MAX_SEGMENTS);
    assign glyph_idx_ok = {20'd0, i_req.table_index} < 32'(GLYPH_ARRAY_DEPTH);

    // The scan pointer and the segment store read address move together, so
    // the registered read data always belongs to the current pointer.
    always_comb begin
        if (i_cmd.seg_clr) begin
            n_idx = '0;
        end else if (i_cmd.seg_inc) begin
            n_idx = SAW'(r_idx + 1'b1);
        end else begin
            n_idx = r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.seg_wr && seg_idx_ok) begin
            r_seg_mem[SAW'(i_req.table_index)] <= '{
                range_offset: i_req.range_offset,
                id_delta:     i_req.id_delta,
                start_code:   i_req.start_code,
                stop_code:    i_req.stop_code
            };
        end
        r_seg_rd <= r_seg_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.glyph_wr && glyph_idx_ok) begin
            r_glyph_mem[GAW'(i_req.table_index)] <= i_req.glyph_word;
        end
        r_glyph_rd <= r_glyph_mem[r_gidx[GAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    // The index is formed modulo 2^IDX_W; its true value always fits signed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.code_load) begin
            r_code <= i_req.code_point;
        end
        if (i_cmd.idx_load) begin
            r_gidx <= IDX_W'(r_idx) + IDX_W'(r_seg_rd.range_offset[15:1])
                    + IDX_W'(r_code) - IDX_W'(r_seg_rd.start_code)
                    - IDX_W'(r_seg_count);
        end
    end

    assign scan_cnt = (SCAN_W'(r_seg_count) < SCAN_W'(MAX_SEGMENTS))
                    ? SCAN_W'(r_seg_count) : SCAN_W'(MAX_SEGMENTS);
    assign glim     = (IDX_W'(r_glyph_words) < IDX_W'(GLYPH_ARRAY_DEPTH))
                    ? IDX_W'(r_glyph_words) : IDX_W'(GLYPH_ARRAY_DEPTH);

    always_comb begin
        o_sts           = '0;
        o_sts.end_ge    = r_seg_rd.stop_code >= r_code;
        o_sts.start_gt  = r_seg_rd.start_code > r_code;
        o_sts.ro_zero   = r_seg_rd.range_offset == 16'd0;
        o_sts.scan_last = SCAN_W'(r_idx) == (scan_cnt - SCAN_W'(1));
        o_sts.scan_zero = r_seg_count == 8'd0;
        o_sts.idx_oor   = r_gidx[IDX_W-1] || (r_gidx >= glim);
        o_sts.out_free  = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_UNCOV: begin
                    r_res_gid    <= 16'd0;
                    r_res_status <= ST_UNCOV;
                end
                RES_DELTA: begin
                    r_res_gid    <= r_seg_rd.id_delta + r_code;
                    r_res_status <= ST_MAPPED;
                end
                RES_OOR: begin
                    r_res_gid    <= 16'd0;
                    r_res_status <= ST_OOR;
                end
                RES_GLYPH: begin
                    // A zero array word gives glyph id zero; the delta is not added.
                    r_res_gid    <= (r_glyph_rd == 16'd0) ? 16'd0
                                  : r_glyph_rd + r_seg_rd.id_delta;
                    r_res_status <= ST_MAPPED;
                end
                default: begin
                    r_res_gid    <= 16'd0;
                    r_res_status <= ST_UNCOV;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_gid    <= r_res_gid;
            r_out_status <= r_res_status;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_glyph_id      = r_out_gid;
    assign o_lookup_status = r_out_status;

endmodule

`default_nettype wire

@@ hw/rtl/glyph_index_lookup_format4.sv @@
// ----------------------------------------------------------------------------
// glyph_index_lookup_format4
// Maps a 16-bit character code to a glyph id through a format-4 segment table.
// ----------------------------------------------------------------------------
// Segment and glyph-array loads leave the block ready and give no result.
// A lookup scans the segment store one entry a cycle through its single read
// port and stops at the first segment whose end code is at or above the code.
// It ends as uncovered when that segment's start is above the code and by
// delta mapping when its range offset is zero; otherwise it forms the array
// index, checks its range, ends as out of range if it fails and else reads
// the glyph array. A code above every scanned end code ends as uncovered
// after the last scanned segment, and a segment count of zero ends as
// uncovered without a scan. The scan sets the longest lookup; an output
// register that still holds an untaken result adds the wait until it is taken.
// The result then sits in an output register while the next item is taken.
// Neither store is cleared after reset; entries must be loaded before use.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_index_lookup_format4
    import gil4_pkg::*;
#(
    parameter int MAX_SEGMENTS      = 128,
    parameter int GLYPH_ARRAY_DEPTH = 4096
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // table_index, stop_code, start_code, id_delta, range_offset, glyph_word,
    // code_point, then four spare bits
    input  wire logic [REQ_DATA_W-1:0]  s_axis_tdata,
    // req_type
    input  wire logic [1:0]             s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // glyph_id
    output logic [15:0]                 m_axis_tdata,
    // lookup_status
    output logic [1:0]                  m_axis_tuser
);

    t_cmd cmd;
    t_sts sts;

    gil4_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_req_type (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gil4_dp #(
        .MAX_SEGMENTS      (MAX_SEGMENTS),
        .GLYPH_ARRAY_DEPTH (GLYPH_ARRAY_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_req           (t_req'(s_axis_tdata)),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (m_axis_tvalid),
        .i_out_ready     (m_axis_tready),
        .o_glyph_id      (m_axis_tdata),
        .o_lookup_status (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ hw/rtl/gil4_checker.sv @@
// ----------------------------------------------------------------------------
// gil4_checker
// Port-level checks on the glyph index lookup block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gil4_checker
    import gil4_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  s_axis_tvalid,
    input wire logic                  s_axis_tready,
    input wire logic [1:0]            s_axis_tuser,
    input wire logic                  m_axis_tvalid,
    input wire logic                  m_axis_tready,
    input wire logic [15:0]           m_axis_tdata,
    input wire logic [1:0]            m_axis_tuser
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before it was taken");

    // Unmapped results always carry glyph id zero.
    a_unmapped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_MAPPED) |-> m_axis_tdata == 16'd0)
        else $error("unmapped result with a nonzero glyph id");

    // A lookup keeps the block busy after it is taken, also with a segment count of zero.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == REQ_LOOKUP)
        |=> !s_axis_tready)
        else $error("item taken right after a lookup");

    // Loads finish in the cycle they are taken.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != REQ_LOOKUP)
        |=> s_axis_tready)
        else $error("block busy after a load");

endmodule

bind glyph_index_lookup_format4 gil4_checker u_gil4_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
